// File: src/swld_pkg.sv
// ----------------------------------------------------------------------------
// Sync word deframer package
// Types and constants shared by the sync word, length-prefixed deframer.
// ----------------------------------------------------------------------------
package swld_pkg;

  // Header sync bytes, in order of arrival.
  localparam logic [7:0] SYNC_FIRST = 8'h5A;
  localparam logic [7:0] SYNC_SECOND = 8'hA5;

  // Smallest payload length that a header may announce.
  localparam logic [15:0] MIN_LENGTH = 16'd2;

  // Largest accepted payload length after reset.
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd1024;

  // Result kinds.
  localparam logic EVT_PAYLOAD = 1'b0;
  localparam logic EVT_FRAMING_ERROR = 1'b1;

  // One result item.
  typedef struct packed {
    logic        event_kind;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] frame_length;
  } result_t;

  // Handshake between the frame controller and the output register.
  typedef struct packed {
    logic    load;
    result_t result;
  } out_load_t;

endpackage

// File: src/swld_frame_ctrl.sv
// ----------------------------------------------------------------------------
// Sync word deframer frame controller
// Tracks header search and payload streaming, and decodes one byte per cycle
// while advance_i is high, into at most one result item.
// ----------------------------------------------------------------------------
module swld_frame_ctrl
  import swld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  byte_i,
  input  logic [15:0] max_length_i,
  input  logic        advance_i,
  output logic        has_result_o,
  output result_t     result_o
);

  // Frame position: four header steps and the payload phase.
  typedef enum logic [4:0] {
    ST_SYNC1   = 5'b00001,
    ST_SYNC2   = 5'b00010,
    ST_LEN_HI  = 5'b00100,
    ST_LEN_LO  = 5'b01000,
    ST_PAYLOAD = 5'b10000
  } frame_state_e;

  frame_state_e state_q, state_d;
  logic [7:0]   length_high_q, length_high_d;
  logic [15:0]  payload_length_q, payload_length_d;
  logic [15:0]  bytes_received_q, bytes_received_d;

  logic [15:0]  header_length;
  logic [15:0]  count_next;
  logic         is_last;
  logic         length_bad;

  assign header_length = {length_high_q, byte_i};
  assign count_next    = bytes_received_q + 16'd1;
  assign is_last       = (count_next == payload_length_q);
  assign length_bad    = (header_length < MIN_LENGTH) || (header_length > max_length_i);

  // Decode the current byte against the frame position.
  always_comb begin
    state_d          = state_q;
    length_high_d    = length_high_q;
    payload_length_d = payload_length_q;
    bytes_received_d = bytes_received_q;
    has_result_o     = 1'b0;
    result_o.event_kind   = EVT_FRAMING_ERROR;
    result_o.data_byte    = byte_i;
    result_o.last_byte    = 1'b0;
    result_o.frame_length = 16'd0;
    unique case (state_q)
      ST_SYNC1: begin
        if (byte_i == SYNC_FIRST) begin
          state_d = ST_SYNC2;
        end else begin
          has_result_o = 1'b1;
        end
      end
      ST_SYNC2: begin
        if (byte_i == SYNC_SECOND) begin
          state_d = ST_LEN_HI;
        end else begin
          state_d      = ST_SYNC1;
          has_result_o = 1'b1;
        end
      end
      ST_LEN_HI: begin
        length_high_d = byte_i;
        state_d       = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        if (length_bad) begin
          state_d               = ST_SYNC1;
          has_result_o          = 1'b1;
          result_o.frame_length = header_length;
        end else begin
          state_d          = ST_PAYLOAD;
          payload_length_d = header_length;
          bytes_received_d = 16'd0;
        end
      end
      ST_PAYLOAD: begin
        has_result_o          = 1'b1;
        result_o.event_kind   = EVT_PAYLOAD;
        result_o.last_byte    = is_last;
        result_o.frame_length = payload_length_q;
        if (is_last) begin
          state_d          = ST_SYNC1;
          bytes_received_d = 16'd0;
        end else begin
          bytes_received_d = count_next;
        end
      end
      default: begin
        state_d = ST_SYNC1;
      end
    endcase
  end

  // Frame state moves only when the byte is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_SYNC1;
      length_high_q    <= 8'd0;
      payload_length_q <= 16'd0;
      bytes_received_q <= 16'd0;
    end else if (advance_i) begin
      state_q          <= state_d;
      length_high_q    <= length_high_d;
      payload_length_q <= payload_length_d;
      bytes_received_q <= bytes_received_d;
    end
  end

endmodule

// File: src/swld_out_reg.sv
// ----------------------------------------------------------------------------
// Sync word deframer output register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module swld_out_reg
  import swld_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  out_load_t load_i,
  input  logic      stall_i,
  output logic      ready_o,
  output logic      valid_o,
  output result_t   result_o
);

  logic    valid_q;
  result_t result_q;

  // The register can take a new item when empty or being drained.
  assign ready_o  = !valid_q || !stall_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i.load;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && load_i.load) begin
      result_q <= load_i.result;
    end
  end

endmodule

// File: src/sync_word_length_deframer.sv
// ----------------------------------------------------------------------------
// Sync word length-prefixed deframer
// The result item of an accepted byte is loaded from the input register into
// the output register. Accepted header bytes give no result item.
// Throughput: one byte per cycle while out_stall_i is low; the input and
// output registers are both emptied in the same cycle as they are refilled.
// Reset: clears the valid flags and returns to sync search; max_length is
// 1024 after reset.
// ----------------------------------------------------------------------------
module sync_word_length_deframer
  import swld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        event_kind_o,
  output logic [7:0]  data_byte_o,
  output logic        last_byte_o,
  output logic [15:0] frame_length_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic [15:0] max_length_q;
  logic        has_result;
  logic        out_ready;
  logic        advance;
  result_t     result;
  result_t     out_result;
  out_load_t   out_load;

  // A byte in the input register is consumed once its result has room.
  assign advance    = in_valid_q && (!has_result || out_ready);
  assign in_stall_o = in_valid_q && !advance;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MAX_LENGTH_RESET;
    end else if (cfg_we_i) begin
      max_length_q <= cfg_wdata_i;
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register byte.
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  swld_frame_ctrl u_frame_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (in_byte_q),
    .max_length_i (max_length_q),
    .advance_i    (advance),
    .has_result_o (has_result),
    .result_o     (result)
  );

  assign out_load.load   = advance && has_result;
  assign out_load.result = result;

  swld_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (out_load),
    .stall_i  (out_stall_i),
    .ready_o  (out_ready),
    .valid_o  (out_valid_o),
    .result_o (out_result)
  );

  assign event_kind_o   = out_result.event_kind;
  assign data_byte_o    = out_result.data_byte;
  assign last_byte_o    = out_result.last_byte;
  assign frame_length_o = out_result.frame_length;

endmodule
